[hw/rtl/ascii_integer_literal_parser_assert.svh]
// Assertion macros shared by the integer literal parser RTL.
// Included by aip_core.sv and ascii_integer_literal_parser.sv; needs no package.
`ifndef ASCII_INTEGER_LITERAL_PARSER_ASSERT_SVH
`define ASCII_INTEGER_LITERAL_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Property that must hold at the same edge
`define AIP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Property checked at the next edge after the antecedent
`define AIP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AIP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define AIP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[hw/rtl/aip_pkg.sv]
// Types and constants for the ASCII integer literal parser.
// No dependencies; used by the interfaces, aip_core and the top level.
`default_nettype none

package aip_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned STAT_W  = 2;

  // ASCII codes the parser looks for
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [VALUE_W-1:0] MAG_MSB_MASK = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_ZERO   = 3'd1,
    PH_DEC    = 3'd2,
    PH_MINUS  = 3'd3,
    PH_HEXPRE = 3'd4,
    PH_HEX    = 3'd5,
    PH_TRAIL  = 3'd6
  } phase_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_SYNTAX  = 2'd1,
    ST_HEXOVF  = 2'd2,
    ST_SIGNOVF = 2'd3
  } status_t;

  // One character handed to the parse core
  typedef struct packed {
    logic              fire;
    logic [CHAR_W-1:0] character;
    logic              last_char;
  } step_t;

  // Parse state right after the current character, before any end-of-literal clear
  typedef struct packed {
    logic [VALUE_W-1:0] acc;
    logic               neg;
    status_t            err;
  } fin_t;

endpackage

`default_nettype wire

[hw/rtl/aip_char_if.sv]
// Input channel: one ASCII character word with its last marker.
// Depends on aip_pkg.
`default_nettype none

interface aip_char_if;
  import aip_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface

`default_nettype wire

[hw/rtl/aip_result_if.sv]
// Result channel: parsed value and status word.
// Depends on aip_pkg.
`default_nettype none

interface aip_result_if;
  import aip_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [STAT_W-1:0]  status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

[hw/rtl/ascii_integer_literal_parser.sv]
// ASCII integer literal parser: one character word per cycle while no last character
// waits on a stalled capture register; one result per literal. A last character moves
// from the input register to the capture register, then to the result register.
// Stages: input register, parse state update with end-of-literal capture, result register.
// Reset (rst_n low, synchronous): clears all valid bits and the parse state.
// Depends on aip_pkg, aip_char_if, aip_result_if, aip_core and the assert header.
`default_nettype none

module ascii_integer_literal_parser (
  input  wire          clk,
  input  wire          rst_n,
  aip_char_if.sink     in_ch,
  aip_result_if.source out_ch
);
  import aip_pkg::*;

  `include "ascii_integer_literal_parser_assert.svh"

  // input register
  logic              a_valid_r;
  logic [CHAR_W-1:0] a_char_r;
  logic              a_last_r;
  logic              a_fire;

  // end-of-literal capture
  logic               f_valid_r;
  logic [VALUE_W-1:0] f_acc_r;
  logic               f_neg_r;
  status_t            f_err_r;
  logic               f_ready;

  // result register
  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  status_t            out_status_r, out_status_nxt;
  logic               o_ready;

  step_t step;
  fin_t  fin;

  // stage readiness, back to front
  assign o_ready     = !out_valid_r || out_ch.ready;
  assign f_ready     = !f_valid_r || o_ready;
  assign a_fire      = a_valid_r && (!a_last_r || f_ready);
  assign in_ch.ready = !a_valid_r || a_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      a_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      a_char_r <= in_ch.character;
      a_last_r <= in_ch.last_char;
    end
  end

  // parse core
  assign step.fire      = a_fire;
  assign step.character = a_char_r;
  assign step.last_char = a_last_r;

  aip_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .fin_o  (fin)
  );

  // capture final state on the last character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (f_ready) begin
      f_valid_r <= a_fire && a_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f_ready && a_fire && a_last_r) begin
      f_acc_r <= fin.acc;
      f_neg_r <= fin.neg;
      f_err_r <= fin.err;
    end
  end

  // sign handling and status
  always_comb begin
    out_value_nxt  = '0;
    out_status_nxt = f_err_r;
    if (f_err_r == ST_OK) begin
      if (!f_neg_r) begin
        out_value_nxt = f_acc_r;
      end else if ((f_acc_r & MAG_MSB_MASK) != '0) begin
        out_status_nxt = ST_SIGNOVF;
      end else begin
        out_value_nxt = '0 - f_acc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_ready) begin
      out_valid_r <= f_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && f_valid_r) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.status = out_status_r;

  `AIP_ASSERT_NOW(a_err_zero_value, clk, rst_n, out_valid_r && out_status_r != ST_OK,
    out_value_r == '0, "nonzero value reported with an error status")
  `AIP_ASSERT_NEXT(a_last_captured, clk, rst_n, a_fire && a_last_r, f_valid_r,
    "last character did not produce a captured result")
  `AIP_ASSERT_NEXT(a_capture_holds, clk, rst_n, f_valid_r && !o_ready,
    f_valid_r && f_acc_r == $past(f_acc_r) && f_err_r == $past(f_err_r),
    "captured result lost while the result register was stalled")

endmodule

`default_nettype wire

[hw/rtl/aip_core.sv]
// Parse state machine: phase, accumulator, sign and sticky error.
// Depends on aip_pkg and ascii_integer_literal_parser_assert.svh.
`default_nettype none

module aip_core (
  input  wire              clk,
  input  wire              rst_n,
  input  aip_pkg::step_t   step_i,
  output aip_pkg::fin_t    fin_o
);
  import aip_pkg::*;

  `include "ascii_integer_literal_parser_assert.svh"

  phase_t             phase_r, phase_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic               neg_r, neg_nxt;
  status_t            err_r, err_nxt;

  logic [CHAR_W-1:0]  ch;
  logic               is_dec, is_hex_lc;
  logic [3:0]         hex_d;
  logic [VALUE_W-1:0] acc_x10;

  // character classes; '0'..'9' keep the digit in the low nibble
  always_comb begin
    ch        = step_i.character;
    is_dec    = (ch >= CH_ZERO) && (ch <= CH_NINE);
    is_hex_lc = (ch >= CH_LC_A) && (ch <= CH_LC_F);
    hex_d     = is_dec ? ch[3:0] : ch[3:0] + 4'd9;
    // acc*10 + digit, wrapping at 64 bits
    acc_x10   = {acc_r[VALUE_W-4:0], 3'b000} + {acc_r[VALUE_W-2:0], 1'b0}
              + {{(VALUE_W-4){1'b0}}, ch[3:0]};
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    err_nxt   = err_r;
    if (err_r == ST_OK) begin
      unique case (phase_r)
        PH_START: begin
          if (ch == CH_ZERO) begin
            phase_nxt = PH_ZERO;
            acc_nxt   = '0;
          end else if (is_dec) begin
            phase_nxt = PH_DEC;
            acc_nxt   = {{(VALUE_W-4){1'b0}}, ch[3:0]};
          end else if (ch == CH_MINUS) begin
            phase_nxt = PH_MINUS;
            acc_nxt   = '0;
            neg_nxt   = 1'b1;
          end else if (ch != CH_SPACE) begin
            err_nxt = ST_SYNTAX;
          end
        end
        PH_ZERO, PH_MINUS: begin
          if (phase_r == PH_ZERO && ch == CH_LC_X) begin
            phase_nxt = PH_HEXPRE;
          end else if (phase_r == PH_MINUS && ch == CH_ZERO) begin
            phase_nxt = PH_ZERO;
          end else if (is_dec) begin
            phase_nxt = PH_DEC;
            acc_nxt   = acc_x10;
          end else begin
            err_nxt = ST_SYNTAX;
          end
        end
        PH_DEC: begin
          if (is_dec) acc_nxt = acc_x10;
          else if (ch == CH_SPACE) phase_nxt = PH_TRAIL;
          else err_nxt = ST_SYNTAX;
        end
        PH_HEXPRE, PH_HEX: begin
          if (!(is_dec || is_hex_lc)) begin
            err_nxt = ST_SYNTAX;
          end else if (acc_r[VALUE_W-1 -: 4] != 4'd0) begin
            // a shift would drop a nonzero top nibble
            err_nxt = ST_HEXOVF;
          end else begin
            acc_nxt   = {acc_r[VALUE_W-5:0], hex_d};
            phase_nxt = PH_HEX;
          end
        end
        PH_TRAIL: begin
          if (ch != CH_SPACE) err_nxt = ST_SYNTAX;
        end
        default: err_nxt = ST_SYNTAX;
      endcase
    end
  end

  // outputs: state after this character
  always_comb begin
    fin_o.acc = acc_nxt;
    fin_o.neg = neg_nxt;
    fin_o.err = err_nxt;
  end

  // state registers; the last character returns everything to reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      err_r   <= ST_OK;
    end else if (step_i.fire) begin
      if (step_i.last_char) begin
        phase_r <= PH_START;
        acc_r   <= '0;
        neg_r   <= 1'b0;
        err_r   <= ST_OK;
      end else begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        neg_r   <= neg_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  `AIP_ASSERT_NEXT(a_clear_after_last, clk, rst_n, step_i.fire && step_i.last_char,
    phase_r == PH_START && err_r == ST_OK && acc_r == '0 && !neg_r,
    "parse state not cleared after last character")
  `AIP_ASSERT_NEXT(a_err_sticky, clk, rst_n,
    err_r != ST_OK && !(step_i.fire && step_i.last_char),
    err_r == $past(err_r) && acc_r == $past(acc_r),
    "sticky error or accumulator changed after an error")

endmodule

`default_nettype wire

[tb/sv/aip_literal_checker.sv]
// Checker for the ASCII integer literal parser: watches both channels,
// predicts each literal's value and status, compares them with what arrives.
// Depends on aip_pkg, aip_char_if and aip_result_if.

module aip_literal_checker (
  input  wire   clk,
  input  wire   rst_n,
  aip_char_if   in_ch,
  aip_result_if out_ch,
  output int    fail_count,
  output int    pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import aip_pkg::*;

  typedef struct {
    logic [VALUE_W-1:0] value;
    status_t            status;
  } literal_result_t;

  // Results of literals whose last word went in, oldest first
  literal_result_t parsed_literals_due[$];

  // Predicted parse state
  phase_t             phase;
  logic [VALUE_W-1:0] magnitude;
  logic               minus_seen;
  status_t            sticky_err;

  function automatic bit is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  task automatic clear_literal();
    phase      = PH_START;
    magnitude  = '0;
    minus_seen = 1'b0;
    sticky_err = ST_OK;
  endtask

  // Advance the predicted state by one character word
  task automatic predict_literal_char(input logic [CHAR_W-1:0] c, input logic last);
    literal_result_t res;
    logic [3:0]      nibble;
    bit              nibble_ok;
    if (sticky_err == ST_OK) begin
      case (phase)
        PH_START: begin
          if (c == CH_ZERO) begin
            phase     = PH_ZERO;
            magnitude = '0;
          end else if (is_digit(c)) begin
            phase     = PH_DEC;
            magnitude = {56'd0, c - CH_ZERO};
          end else if (c == CH_MINUS) begin
            phase      = PH_MINUS;
            magnitude  = '0;
            minus_seen = 1'b1;
          end else if (c != CH_SPACE) begin
            sticky_err = ST_SYNTAX;
          end
        end
        PH_ZERO, PH_MINUS: begin
          if (phase == PH_ZERO && c == CH_LC_X) begin
            phase = PH_HEXPRE;
          end else if (phase == PH_MINUS && c == CH_ZERO) begin
            phase = PH_ZERO;
          end else if (is_digit(c)) begin
            phase     = PH_DEC;
            magnitude = magnitude * 64'd10 + {56'd0, c - CH_ZERO};
          end else begin
            sticky_err = ST_SYNTAX;
          end
        end
        PH_DEC: begin
          // decimal wraps modulo 2^64 without a flag
          if (is_digit(c)) magnitude = magnitude * 64'd10 + {56'd0, c - CH_ZERO};
          else if (c == CH_SPACE) phase = PH_TRAIL;
          else sticky_err = ST_SYNTAX;
        end
        PH_HEXPRE, PH_HEX: begin
          nibble_ok = 1'b1;
          nibble    = '0;
          if (is_digit(c)) nibble = 4'(c - CH_ZERO);
          else if (c >= CH_LC_A && c <= CH_LC_F) nibble = 4'(c - CH_LC_A + 8'd10);
          else nibble_ok = 1'b0;
          if (!nibble_ok) begin
            sticky_err = ST_SYNTAX;
          end else if (magnitude[VALUE_W-1 -: 4] != 4'd0) begin
            // a digit arriving with the top nibble in use would be lost
            sticky_err = ST_HEXOVF;
          end else begin
            magnitude = {magnitude[VALUE_W-5:0], nibble};
            phase     = PH_HEX;
          end
        end
        PH_TRAIL: begin
          if (c != CH_SPACE) sticky_err = ST_SYNTAX;
        end
        default: sticky_err = ST_SYNTAX;
      endcase
    end

    // End of literal: build the result and start over
    if (last) begin
      res.value  = '0;
      res.status = sticky_err;
      if (sticky_err == ST_OK) begin
        if (!minus_seen) res.value = magnitude;
        else if ((magnitude & MAG_MSB_MASK) != '0) res.status = ST_SIGNOVF;
        else res.value = -magnitude;
      end
      parsed_literals_due.push_back(res);
      clear_literal();
    end
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin : monitor
    literal_result_t due;
    if (!rst_n) begin
      clear_literal();
      parsed_literals_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (parsed_literals_due.size() == 0) begin
          $error("result word with no literal pending: value %h status %0d",
                 out_ch.value, out_ch.status);
          fail_count++;
        end else begin
          due = parsed_literals_due.pop_front();
          if (out_ch.value !== due.value) begin
            $error("value: expected %h, got %h", due.value, out_ch.value);
            fail_count++;
          end
          if (out_ch.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, out_ch.status);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) predict_literal_char(in_ch.character, in_ch.last_char);
    end
    pending_count = parsed_literals_due.size();
  end

endmodule

[tb/sv/tb_top.sv]
// Top of the parser testbench: clock, reset, character stimulus, result
// backpressure and the verdict. Needs aip_pkg, both interfaces, the parser and aip_literal_checker.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import aip_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   chars_sent;
  bit   no_idle;

  // Characters of the literal being sent
  logic [CHAR_W-1:0] literal_chars[$];

  string directed_lits[8] = '{"-0x1f", "07 ", "0 ", "-", "0x", " ", "0xg", "5-"};
  string wide_vals[4] = '{"9223372036854775807", "9223372036854775808",
                          "18446744073709551615", "18446744073709551616"};
  string hex_set = "0123456789abcdef";

  aip_char_if   in_ch();
  aip_result_if out_ch();

  ascii_integer_literal_parser u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  aip_literal_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic append_text(input string text);
    for (int i = 0; i < text.len(); i++) literal_chars.push_back(text[i]);
  endtask

  // Send the queued characters, last marker on the final word
  task automatic send_literal();
    int gap;
    for (int i = 0; i < literal_chars.size(); i++) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_ch.valid     <= 1'b1;
      in_ch.character <= literal_chars[i];
      in_ch.last_char <= (i == literal_chars.size() - 1);
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      @(negedge clk);
      chars_sent++;
    end
  endtask

  // Result side backpressure
  int stall_left;
  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 7) == 0) stall_left <= pick_gap();
    end
  end

  initial begin : stimulus
    int kind;
    int n;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.character = '0;
    in_ch.last_char = 1'b0;
    no_idle         = 1'b0;
    stall_left      = 0;
    chars_sent      = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: hex after minus-zero, leading zero, incomplete literals, bad chars
    foreach (directed_lits[i]) begin
      literal_chars.delete();
      append_text(directed_lits[i]);
      send_literal();
    end
    literal_chars = '{8'h00};
    send_literal();
    literal_chars = '{CH_NINE, 8'hff};
    send_literal();

    // Random literals: mostly well formed, some broken or truncated, some noise
    while (chars_sent < 1830) begin
      no_idle = ($urandom_range(0, 9) == 0);
      literal_chars.delete();
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) literal_chars.push_back(CH_SPACE);
      if ($urandom_range(0, 2) == 0) literal_chars.push_back(CH_MINUS);
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        literal_chars.delete();
        repeat ($urandom_range(1, 5)) literal_chars.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 48) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 22) : $urandom_range(1, 6);
        if ($urandom_range(0, 5) == 0) literal_chars.push_back(CH_ZERO);
        repeat (n) literal_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 2)) literal_chars.push_back(CH_SPACE);
        end
      end else if (kind < 88) begin
        literal_chars.push_back(CH_ZERO);
        literal_chars.push_back(CH_LC_X);
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(14, 17) : $urandom_range(1, 4);
        repeat (n) literal_chars.push_back(hex_set[$urandom_range(0, 15)]);
      end else begin
        append_text(wide_vals[$urandom_range(0, 3)]);
      end

      // Damage some literals
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        literal_chars[$urandom_range(0, literal_chars.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind < 14) begin
        n = $urandom_range(1, literal_chars.size());
        while (literal_chars.size() > n) void'(literal_chars.pop_back());
      end else if (kind < 18) begin
        literal_chars.push_back(CH_SPACE);
      end
      send_literal();
    end
    in_ch.valid <= 1'b0;
    no_idle = 1'b0;

    // Drain, then allow for the pipeline
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("ascii_integer_literal_parser test passed");
    end else begin
      $display("ascii_integer_literal_parser test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6_000_000;
    $display("ascii_integer_literal_parser test failed");
    $finish;
  end

endmodule
